@@ rtl/core/bitcrusher_with_allpass_filter_top_macros.svh @@
// Assertion macros for the bitcrusher top level.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BITCRUSHER_WITH_ALLPASS_FILTER_TOP_MACROS_SVH
`define BITCRUSHER_WITH_ALLPASS_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bcap_pkg.sv @@
// Shared types, constants and arithmetic helpers of the bitcrusher block.
// No dependencies; imported by every module of the block.
package bcap_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_W         = 1;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int SAMPLE_W     = 24;
    localparam int FRAC_BITS    = SAMPLE_W - 1;
    localparam int DELAY_W      = SAMPLE_W + 2;
    localparam int COEFF_W      = 16;
    localparam int COEFF_FRAC   = 15;
    localparam int MIX_W        = 13;
    localparam int MIX_FRAC     = 12;
    localparam int MIX_ONE      = 4096;
    localparam int LVL_W        = SAMPLE_W - 1;
    localparam int HOLD_W       = 9;
    localparam int HOLD_MAX     = 256;
    localparam int PHASE_W      = 8;
    localparam int BITS_W       = 5;
    localparam int BITS_MIN     = 2;
    localparam int BITS_MAX     = 24;
    localparam int DIV_STEPS    = SAMPLE_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam int MUL_A_W      = DELAY_W;
    localparam int MUL_B_W      = SAMPLE_W;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int ACC_W        = SAMPLE_W + MIX_W + 1;
    localparam int RS_W         = PROD_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_DEPTH   = 3'd0,
        REG_HOLD_FACTOR = 3'd1,
        REG_MIX_LEVEL   = 3'd2,
        REG_FILTER_EN   = 3'd3,
        REG_HP_MODE     = 3'd4,
        REG_COEFF       = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [LVL_W-1:0]          levels;
        logic [HOLD_W-1:0]         hold;
        logic [MIX_W-1:0]          mix;
        logic                      filt_en;
        logic                      hp_mode;
        logic signed [COEFF_W-1:0] coeff;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_QUANT,
        MUL_FILT_U,
        MUL_FILT_Y,
        MUL_DRY,
        MUL_WET
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        mul_op_t mul_op;
        logic    q_setup;
        logic    div_step;
        logic    q_write;
        logic    f_y;
        logic    f_delay;
        logic    acc_load;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_zero;
        logic div_last;
        logic out_busy;
    } dp_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QMUL,
        ST_QSETUP,
        ST_DIV,
        ST_QSAT,
        ST_FMUL1,
        ST_FY,
        ST_FMUL2,
        ST_FDLY,
        ST_MMUL1,
        ST_MMUL2,
        ST_MSUM
    } ctrl_state_t;

    // Divide by 2^sh, rounding half away from zero (sh >= 1).
    function automatic logic signed [RS_W-1:0] round_shr(
        input logic signed [RS_W-1:0] v,
        input logic [5:0]             sh
    );
        logic signed [RS_W-1:0] half;
        logic signed [RS_W-1:0] neg;
        logic signed [RS_W-1:0] sum;
        half = {{(RS_W-1){1'b0}}, 1'b1} << (sh - 6'd1);
        neg  = {{(RS_W-1){1'b0}}, v[RS_W-1]};
        sum  = v + half - neg;
        return sum >>> sh;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [RS_W-1:0] v
    );
        if (v[RS_W-1:SAMPLE_W-1] == '0 || v[RS_W-1:SAMPLE_W-1] == '1) begin
            return v[SAMPLE_W-1:0];
        end else if (v[RS_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [RS_W-1:0] v
    );
        if (v[RS_W-1:DELAY_W-1] == '0 || v[RS_W-1:DELAY_W-1] == '1) begin
            return v[DELAY_W-1:0];
        end else if (v[RS_W-1]) begin
            return {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DELAY_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ rtl/core/bcap_cfg.sv @@
// Configuration register file: takes register writes and keeps clamped values.
// Depends on bcap_pkg.
module bcap_cfg
    import bcap_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [LVL_W-1:0]          levels_reg;
    logic [HOLD_W-1:0]         hold_reg;
    logic [MIX_W-1:0]          mix_reg;
    logic                      filt_en_reg;
    logic                      hp_reg;
    logic signed [COEFF_W-1:0] coeff_reg;

    logic [BITS_W-1:0] bits_raw;
    logic [BITS_W-1:0] bits_c;
    logic [LVL_W:0]    lvl_wide;
    logic [HOLD_W-1:0] hold_raw;
    logic [HOLD_W-1:0] hold_c;
    logic [MIX_W-1:0]  mix_raw;
    logic [MIX_W-1:0]  mix_c;

    assign cfg_ready = 1'b1;

    always_comb begin
        bits_raw = cfg_data[BITS_W-1:0];
        if (bits_raw < BITS_W'(BITS_MIN)) begin
            bits_c = BITS_W'(BITS_MIN);
        end else if (bits_raw > BITS_W'(BITS_MAX)) begin
            bits_c = BITS_W'(BITS_MAX);
        end else begin
            bits_c = bits_raw;
        end
        // levels = 2^(bits-1) - 1
        lvl_wide = ({{LVL_W{1'b0}}, 1'b1} << (bits_c - BITS_W'(1))) - (LVL_W+1)'(1);

        hold_raw = cfg_data[HOLD_W-1:0];
        if (hold_raw == '0) begin
            hold_c = HOLD_W'(1);
        end else if (hold_raw > HOLD_W'(HOLD_MAX)) begin
            hold_c = HOLD_W'(HOLD_MAX);
        end else begin
            hold_c = hold_raw;
        end

        mix_raw = cfg_data[MIX_W-1:0];
        mix_c   = (mix_raw > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : mix_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg  <= LVL_W'(127);
            hold_reg    <= HOLD_W'(1);
            mix_reg     <= MIX_W'(MIX_ONE);
            filt_en_reg <= 1'b0;
            hp_reg      <= 1'b0;
            coeff_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BIT_DEPTH:   levels_reg  <= lvl_wide[LVL_W-1:0];
                REG_HOLD_FACTOR: hold_reg    <= hold_c;
                REG_MIX_LEVEL:   mix_reg     <= mix_c;
                REG_FILTER_EN:   filt_en_reg <= cfg_data[0];
                REG_HP_MODE:     hp_reg      <= cfg_data[0];
                REG_COEFF:       coeff_reg   <= cfg_data[COEFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.levels  = levels_reg;
    assign cfg.hold    = hold_reg;
    assign cfg.mix     = mix_reg;
    assign cfg.filt_en = filt_en_reg;
    assign cfg.hp_mode = hp_reg;
    assign cfg.coeff   = coeff_reg;

endmodule

@@ rtl/core/bcap_ctrl.sv @@
// Sequencer of the bitcrusher: steps one sample through quantize (on a new hold value), filter (when enabled) and mix.
// Depends on bcap_pkg; drives the command struct of bcap_dp.
module bcap_ctrl
    import bcap_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    filt_en,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.phase_zero) begin
                        state_next = ST_QMUL;
                    end else if (filt_en) begin
                        state_next = ST_FMUL1;
                    end else begin
                        state_next = ST_MMUL1;
                    end
                end
            end
            ST_QMUL: begin
                cmd.mul_op = MUL_QUANT;
                state_next = ST_QSETUP;
            end
            ST_QSETUP: begin
                cmd.q_setup = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_QSAT;
                end
            end
            ST_QSAT: begin
                cmd.q_write = 1'b1;
                state_next  = filt_en ? ST_FMUL1 : ST_MMUL1;
            end
            ST_FMUL1: begin
                cmd.mul_op = MUL_FILT_U;
                state_next = ST_FY;
            end
            ST_FY: begin
                cmd.f_y    = 1'b1;
                state_next = ST_FMUL2;
            end
            ST_FMUL2: begin
                cmd.mul_op = MUL_FILT_Y;
                state_next = ST_FDLY;
            end
            ST_FDLY: begin
                cmd.f_delay = 1'b1;
                state_next  = ST_MMUL1;
            end
            ST_MMUL1: begin
                cmd.mul_op = MUL_DRY;
                state_next = ST_MMUL2;
            end
            ST_MMUL2: begin
                cmd.mul_op   = MUL_WET;
                cmd.acc_load = 1'b1;
                state_next   = ST_MSUM;
            end
            ST_MSUM: begin
                // hold until the output register is free
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bcap_dp.sv @@
// Datapath: channel state, shared multiplier, bit-serial divider, output register.
// Depends on bcap_pkg; controlled by bcap_ctrl through dp_cmd_t / dp_sts_t.
module bcap_dp
    import bcap_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [CH_W-1:0]     s_tuser,
    input  logic [SAMPLE_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output logic [CH_W-1:0]     m_tuser
);

    logic [CH_W-1:0]            ch_reg;
    logic signed [SAMPLE_W-1:0] dry_reg;
    logic signed [SAMPLE_W-1:0] held_reg  [NUM_CHANNELS];
    logic [PHASE_W-1:0]         phase_reg [NUM_CHANNELS];
    logic signed [DELAY_W-1:0]  delay_reg [NUM_CHANNELS];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic [SAMPLE_W-1:0]        rem_reg;
    logic [SAMPLE_W-1:0]        quot_reg;
    logic [SAMPLE_W-1:0]        low_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [DELAY_W-1:0]  y_reg;
    logic signed [DELAY_W-1:0]  wet_reg;
    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic [CH_W-1:0]            m_user_reg;

    logic [CH_IDX_W-1:0]        idx_in;
    logic [CH_IDX_W-1:0]        idx;
    logic [HOLD_W-1:0]          phase_inc;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic [MIX_W:0]             mix_inv;
    logic [SAMPLE_W-1:0]        div_d;
    logic signed [RS_W-1:0]     k_val;
    logic [RS_W-1:0]            k_mag;
    logic [SAMPLE_W:0]          div_shift;
    logic                       div_ge;
    logic [SAMPLE_W:0]          div_trial;
    logic signed [SAMPLE_W:0]   q_signed;
    logic signed [RS_W-1:0]     ap_val;
    logic signed [RS_W-1:0]     u_val;
    logic signed [RS_W-1:0]     uy_sum;
    logic signed [RS_W-1:0]     mix_sum;

    assign idx_in    = s_tuser[CH_IDX_W-1:0];
    assign idx       = ch_reg[CH_IDX_W-1:0];
    assign phase_inc = {1'b0, phase_reg[idx_in]} + HOLD_W'(1);
    assign mix_inv   = (MIX_W+1)'(MIX_ONE) - {1'b0, cfg.mix};
    assign div_d     = {cfg.levels, 1'b0};

    // shared multiplier operand select
    always_comb begin
        unique case (cmd.mul_op)
            MUL_QUANT: begin
                mul_a = MUL_A_W'(dry_reg);
                mul_b = $signed({1'b0, cfg.levels});
            end
            MUL_FILT_U: begin
                mul_a = MUL_A_W'(held_reg[idx]);
                mul_b = MUL_B_W'(cfg.coeff);
            end
            MUL_FILT_Y: begin
                mul_a = y_reg;
                mul_b = MUL_B_W'(cfg.coeff);
            end
            MUL_DRY: begin
                mul_a = MUL_A_W'(dry_reg);
                mul_b = $signed(MUL_B_W'(mix_inv));
            end
            MUL_WET: begin
                mul_a = cfg.filt_en ? wet_reg : MUL_A_W'(held_reg[idx]);
                mul_b = $signed(MUL_B_W'(cfg.mix));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        k_val     = round_shr(RS_W'(prod_reg), 6'(FRAC_BITS));
        k_mag     = k_val[RS_W-1] ? RS_W'(-k_val) : RS_W'(k_val);
        div_shift = {rem_reg, low_reg[SAMPLE_W-1]};
        div_ge    = div_shift >= {1'b0, div_d};
        div_trial = div_shift - {1'b0, div_d};
        q_signed  = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        ap_val    = round_shr(RS_W'(prod_reg), 6'(COEFF_FRAC));
        u_val     = RS_W'(held_reg[idx]);
        uy_sum    = cfg.hp_mode ? (u_val - RS_W'(y_reg)) : (u_val + RS_W'(y_reg));
        mix_sum   = RS_W'(acc_reg) + RS_W'(prod_reg);
    end

    // per-channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                held_reg[c]  <= '0;
                phase_reg[c] <= '0;
                delay_reg[c] <= '0;
            end
        end else begin
            if (cmd.accept) begin
                phase_reg[idx_in] <= (phase_inc >= cfg.hold) ? '0
                                                             : phase_inc[PHASE_W-1:0];
            end
            if (cmd.q_write) begin
                held_reg[idx] <= sat_sample(RS_W'(q_signed));
            end
            if (cmd.f_delay) begin
                delay_reg[idx] <= sat_delay(u_val - ap_val);
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ch_reg  <= s_tuser;
            dry_reg <= s_tdata;
        end
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.q_setup) begin
            neg_reg  <= k_val[RS_W-1];
            rem_reg  <= k_mag[SAMPLE_W-1:0];
            low_reg  <= {1'b0, cfg.levels};
            quot_reg <= '0;
            cnt_reg  <= CNT_W'(DIV_STEPS - 1);
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_trial[SAMPLE_W-1:0] : div_shift[SAMPLE_W-1:0];
            quot_reg <= {quot_reg[SAMPLE_W-2:0], div_ge};
            low_reg  <= {low_reg[SAMPLE_W-2:0], 1'b0};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        if (cmd.f_y) begin
            y_reg <= sat_delay(ap_val + RS_W'(delay_reg[idx]));
        end
        if (cmd.f_delay) begin
            wet_reg <= DELAY_W'(round_shr(uy_sum, 6'd1));
        end
        if (cmd.acc_load) begin
            acc_reg <= ACC_W'(prod_reg);
        end
        if (cmd.out_load) begin
            m_data_reg <= sat_sample(round_shr(mix_sum, 6'(MIX_FRAC)));
            m_user_reg <= ch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.phase_zero = (phase_reg[idx_in] == '0);
    assign sts.div_last   = (cnt_reg == '0);
    assign sts.out_busy   = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/core/bitcrusher_with_allpass_filter_top.sv @@
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tdata: sample_in; s_tuser: channel_id
// m_        out  m_tvalid / m_tready    m_tdata: sample_out; m_tuser: channel_out
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample at a time. After acceptance, a value that is quantized anew goes through the
// quantize multiply, divider setup, bit-serial divider and saturation; with the filter
// enabled it takes two passes through the shared multiplier; then the dry and wet products
// are summed into the output register, and the next transaction is taken after that load.
// aresetn is synchronous; all channel state clears.
// A stalled m_ side blocks only while a finished result waits on a full output register.
// Depends on bcap_pkg, bcap_cfg, bcap_ctrl, bcap_dp and the macros header.
`include "bitcrusher_with_allpass_filter_top_macros.svh"

module bitcrusher_with_allpass_filter_top
    import bcap_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
    input  logic [CH_W-1:0]       s_tuser,   // [0] channel_id
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
    output logic [CH_W-1:0]       m_tuser,   // [0] channel_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    bcap_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .filt_en  (cfg.filt_en),
        .sts      (sts),
        .cmd      (cmd)
    );

    bcap_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `BCAP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second sample taken while busy")
    `BCAP_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(m_tvalid && !m_tready), "pending result overwritten")
    `BCAP_ASSERT_NOW(a_quant_after_div, cmd.q_write, $past(cmd.div_step) && $past(sts.div_last), "held value written before divide finished")

endmodule

@@ tb/sv/bitcrusher_with_allpass_filter_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bitcrusher_with_allpass_filter_top: streams samples and
// register writes with random gaps and stalls, and checks each result against its own
// model of the quantizer, hold, filter and mix. Depends on bcap_pkg and the RTL only.

module bitcrusher_with_allpass_filter_top_test;
    import bcap_pkg::*;

    localparam int STUCK_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1300;

    typedef struct {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
    } crushed_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic [CH_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic [CH_W-1:0]       m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and per-channel state
    int unsigned               bits_reg;
    int unsigned               hold_reg;
    int unsigned               mix_reg;
    bit                        filt_reg;
    bit                        hp_reg;
    logic signed [COEFF_W-1:0] coeff_reg;
    longint                    held_level [NUM_CHANNELS];
    int unsigned               hold_ctr   [NUM_CHANNELS];
    longint                    delay_line [NUM_CHANNELS];

    crushed_t expected_q [$];
    crushed_t head_result;

    int  errors         = 0;
    int  samples_sent   = 0;
    int  results_seen   = 0;
    int  reg_writes     = 0;
    int  random_phases  = 0;
    int  src_gap_pct    = 30;
    int  sink_stall_pct = 30;
    int  stall_left     = 0;
    int  stuck_cycles   = 0;
    bit  src_active     = 1'b0;
    bit  cfg_active     = 1'b0;

    bitcrusher_with_allpass_filter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Divide by 2^s, rounding half away from zero
    function automatic longint round_away(input longint v, input int s);
        longint unsigned mag;
        if (v < 0) begin
            mag = -v;
        end else begin
            mag = v;
        end
        mag = (mag + (64'd1 << (s - 1))) >> s;
        if (v < 0) begin
            return -longint'(mag);
        end
        return longint'(mag);
    endfunction

    function automatic longint clamp_width(input longint v, input int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint quantize_level(input longint x, input int unsigned bits);
        longint          levels;
        longint          k;
        longint unsigned mag;
        longint unsigned q;
        levels = (longint'(1) << (bits - 1)) - 1;
        k = round_away(x * levels, FRAC_BITS);
        if (k < 0) begin
            mag = -k;
        end else begin
            mag = k;
        end
        // k * 2^23 / L, rounded half away
        q = ((mag << FRAC_BITS) * 2 + longint'(levels)) / (2 * levels);
        if (k < 0) begin
            return clamp_width(-longint'(q), SAMPLE_W);
        end
        return clamp_width(longint'(q), SAMPLE_W);
    endfunction

    // Advance the per-channel state for one accepted sample and return its result
    function automatic crushed_t crush_sample(input logic [CH_W-1:0] ch_id,
                                              input logic [SAMPLE_W-1:0] x);
        crushed_t    r;
        int          c;
        int unsigned bits;
        int unsigned hold;
        int unsigned nxt;
        longint      mix;
        longint      dry;
        longint      wet;
        longint      a;
        longint      y;
        longint      acc;
        c    = ch_id % NUM_CHANNELS;
        dry  = longint'($signed(x));
        bits = (bits_reg < BITS_MIN) ? BITS_MIN : (bits_reg > BITS_MAX) ? BITS_MAX : bits_reg;
        hold = (hold_reg < 1) ? 1 : (hold_reg > HOLD_MAX) ? HOLD_MAX : hold_reg;
        mix  = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;

        if (hold_ctr[c] == 0) begin
            held_level[c] = quantize_level(dry, bits);
        end
        wet = held_level[c];
        nxt = hold_ctr[c] + 1;
        hold_ctr[c] = (nxt >= hold) ? 0 : (nxt & 8'hFF);

        if (filt_reg) begin
            a = longint'(coeff_reg);
            y = clamp_width(round_away(a * wet, COEFF_FRAC) + delay_line[c], DELAY_W);
            delay_line[c] = clamp_width(wet - round_away(a * y, COEFF_FRAC), DELAY_W);
            wet = round_away(hp_reg ? wet - y : wet + y, 1);
        end

        acc = round_away(dry * (MIX_ONE - mix) + wet * mix, MIX_FRAC);
        acc = clamp_width(acc, SAMPLE_W);
        r.ch     = ch_id;
        r.sample = acc[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic int idle_length();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] edges [5] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                           24'hFFFFFF, 24'h000001};
        case ($urandom_range(0, 9))
            0: begin
                return edges[$urandom_range(0, 4)];
            end
            1: begin
                return SAMPLE_W'($urandom_range(0, 511) - 256);
            end
            default: begin
                return SAMPLE_W'($urandom());
            end
        endcase
    endfunction

    // Sometimes set the bits above the register width; the block must ignore them
    function automatic logic [CFG_DATA_W-1:0] pad_upper(input int unsigned val,
                                                        input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((32'd1 << width) - 1);
        if ($urandom_range(0, 3) == 0) begin
            return (CFG_DATA_W'(val) & keep) | (CFG_DATA_W'($urandom()) & ~keep);
        end
        return CFG_DATA_W'(val) & keep;
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        errors++;
        if (errors <= 100) begin
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, results_seen, got, want);
        end
    endtask

    // Hold the sender until every pending transaction has come back
    task automatic drain_results();
        if (src_active) begin
            s_tvalid <= 1'b0;
            src_active = 1'b0;
            @(posedge aclk);
        end
        while (expected_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_active = 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            REG_BIT_DEPTH:   bits_reg  = val[BITS_W-1:0];
            REG_HOLD_FACTOR: hold_reg  = val[HOLD_W-1:0];
            REG_MIX_LEVEL:   mix_reg   = val[MIX_W-1:0];
            REG_FILTER_EN:   filt_reg  = val[0];
            REG_HP_MODE:     hp_reg    = val[0];
            REG_COEFF:       coeff_reg = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] x);
        int gap;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? idle_length() : 0;
        if (cfg_active) begin
            cfg_valid <= 1'b0;
            cfg_active = 1'b0;
        end
        if (gap > 0) begin
            if (src_active) begin
                s_tvalid <= 1'b0;
                src_active = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= x;
        src_active = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_q.push_back(crush_sample(ch, x));
        samples_sent++;
    endtask

    // Reset settings: 8 bits, no hold, fully wet, filter off
    task automatic test_extreme_samples();
        send_sample(0, 24'h7FFFFF);
        send_sample(1, 24'h800000);
        send_sample(0, 24'h000000);
        send_sample(1, 24'hFFFFFF);
        send_sample(0, 24'h000001);
        send_sample(1, 24'h400000);
    endtask

    task automatic test_bit_depth_limits();
        write_reg(REG_BIT_DEPTH, 16'd0);
        send_sample(0, 24'h7FFFFF);
        send_sample(1, 24'hC00000);     // exactly half a level below zero
        write_reg(REG_BIT_DEPTH, 16'd1);
        send_sample(0, 24'h400000);
        write_reg(REG_BIT_DEPTH, 16'd24);
        send_sample(1, 24'h800000);
        write_reg(REG_BIT_DEPTH, 16'd31);
        send_sample(0, 24'h123456);
        write_reg(REG_BIT_DEPTH, 16'd4);
    endtask

    task automatic test_hold_factor();
        write_reg(REG_HOLD_FACTOR, 16'd0);
        send_sample(1, 24'h333333);
        write_reg(REG_HOLD_FACTOR, 16'd256);
        send_sample(0, 24'h7FFFFF);
        send_sample(0, 24'h800000);
        send_sample(0, 24'h2AAAAA);
        send_sample(1, 24'hD55555);
        // phase of channel 0 now past the new factor: wrap on the next sample
        write_reg(REG_HOLD_FACTOR, 16'd2);
        send_sample(0, 24'h111111);
        send_sample(0, 24'hEEEEEE);
        write_reg(REG_HOLD_FACTOR, 16'd511);
        send_sample(1, 24'h654321);
        write_reg(REG_HOLD_FACTOR, 16'd1);
    endtask

    task automatic test_filter_modes();
        write_reg(REG_BIT_DEPTH, 16'd24);
        write_reg(REG_FILTER_EN, 16'd1);
        write_reg(REG_HP_MODE, 16'd0);
        write_reg(REG_COEFF, 16'h8000);
        send_sample(0, 24'h7FFFFF);
        send_sample(0, 24'h7FFFFF);
        write_reg(REG_HP_MODE, 16'd1);
        write_reg(REG_COEFF, 16'h7FFF);
        send_sample(1, 24'h800000);
        send_sample(1, 24'h800000);
        // delay line must stay untouched while the filter is off
        write_reg(REG_FILTER_EN, 16'd0);
        send_sample(0, 24'h7FFFFF);
    endtask

    task automatic test_mix_levels();
        write_reg(REG_MIX_LEVEL, 16'd0);
        send_sample(1, 24'h800001);
        write_reg(REG_MIX_LEVEL, 16'd8191);
        send_sample(0, 24'h7FFFFE);
        write_reg(REG_FILTER_EN, 16'd1);
        write_reg(REG_MIX_LEVEL, 16'd2048);
        send_sample(0, 24'h7FFFFF);
    endtask

    task automatic test_random_traffic();
        int unsigned bit_edges  [6] = '{0, 1, 2, 24, 25, 31};
        int unsigned hold_edges [6] = '{0, 1, 255, 256, 257, 511};
        int unsigned mix_edges  [4] = '{0, 4096, 4097, 8191};
        int          idle_pcts  [4] = '{0, 5, 25, 60};
        int          start;
        int          n;
        int unsigned val;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS) begin
            val = ($urandom_range(0, 4) == 0) ? bit_edges[$urandom_range(0, 5)]
                                              : $urandom_range(2, 24);
            write_reg(REG_BIT_DEPTH, pad_upper(val, BITS_W));
            case ($urandom_range(0, 9))
                0:       val = hold_edges[$urandom_range(0, 5)];
                1, 2, 3: val = $urandom_range(5, 16);
                default: val = $urandom_range(1, 4);
            endcase
            write_reg(REG_HOLD_FACTOR, pad_upper(val, HOLD_W));
            val = ($urandom_range(0, 3) == 0) ? mix_edges[$urandom_range(0, 3)]
                                              : $urandom_range(0, MIX_ONE);
            write_reg(REG_MIX_LEVEL, pad_upper(val, MIX_W));
            write_reg(REG_FILTER_EN, pad_upper($urandom_range(0, 1), 1));
            write_reg(REG_HP_MODE, pad_upper($urandom_range(0, 1), 1));
            case ($urandom_range(0, 5))
                0:       val = 16'h8000;
                1:       val = 16'h7FFF;
                default: val = $urandom();
            endcase
            write_reg(REG_COEFF, CFG_DATA_W'(val));

            src_gap_pct    = idle_pcts[$urandom_range(0, 3)];
            sink_stall_pct = idle_pcts[$urandom_range(0, 3)];
            for (n = $urandom_range(20, 90); n > 0; n--) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain_results();
                end
                send_sample(CH_W'($urandom_range(0, 1)), pick_sample());
            end
            random_phases++;
        end
    endtask

    // Output side: random stalls, short and long
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= idle_length() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unrequested result", m_tdata, '0);
            end else begin
                head_result = expected_q.pop_front();
                if (m_tuser !== head_result.ch) begin
                    report_mismatch("channel_out", SAMPLE_W'(m_tuser),
                                    SAMPLE_W'(head_result.ch));
                end
                if (m_tdata !== head_result.sample) begin
                    report_mismatch("sample_out", m_tdata, head_result.sample);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge aclk);
        end
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 STUCK_LIMIT, expected_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        bits_reg  = 8;
        hold_reg  = 1;
        mix_reg   = MIX_ONE;
        filt_reg  = 1'b0;
        hp_reg    = 1'b0;
        coeff_reg = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            held_level[c] = 0;
            hold_ctr[c]   = 0;
            delay_line[c] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_samples();
        test_bit_depth_limits();
        test_hold_factor();
        test_filter_modes();
        test_mix_levels();
        test_random_traffic();

        drain_results();
        if (cfg_active) begin
            cfg_valid <= 1'b0;
            cfg_active = 1'b0;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0) begin
            report_mismatch("results never returned", '0, SAMPLE_W'(expected_q.size()));
        end

        $display("Sent %0d samples on both channels, checked %0d results, %0d mismatches.",
                 samples_sent, results_seen, errors);
        $display("Covered %0d register writes over %0d random setting phases.",
                 reg_writes, random_phases);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
